>>> src/sparse_table_range_min_build_macros.svh
// Assertion shorthands for the checker module.
`ifndef SPARSE_TABLE_RANGE_MIN_BUILD_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_BUILD_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define STB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define STB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/stb_pkg.sv
package stb_pkg;

    localparam int DEPTH     = 64;
    localparam int LEVELS    = 7;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int LVL_IN_W  = 3;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int J_W       = $clog2(LEVELS + 1);
    localparam int MEM_DEPTH = LEVELS * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CMP_W     = (LEVELS + 1 > CNT_W + 1) ? LEVELS + 1 : CNT_W + 1;

    // Sequencer steps, in program order.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LVL,
        ST_RD,
        ST_WR,
        ST_NXT,
        ST_DONE
    } t_step;

    // Jump conditions: when true the step counter loads the target.
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NOT_START,
        JC_LVL_FAIL,
        JC_WIN_MORE
    } t_jc;

    typedef struct packed {
        logic i_clr;
        logic i_inc;
        logic j_init;
        logic j_inc;
        logic rd_en;
        logic wr_en;
        logic set_built;
    } t_ctl;

    typedef struct packed {
        logic lvl_fits;
        logic win_more;
    } t_sts;

    typedef struct packed {
        t_jc   jc;
        t_step target;
        t_ctl  ctl;
    } t_ucw;

    // Microcode store: one control word per step.
    function automatic t_ucw ucode_rom(input t_step step);
        t_ucw w;
        w.jc     = JC_NEXT;
        w.target = ST_IDLE;
        w.ctl    = '0;
        case (step)
            ST_IDLE: begin
                w.jc         = JC_NOT_START;
                w.target     = ST_IDLE;
                w.ctl.j_init = 1'b1;
                w.ctl.i_clr  = 1'b1;
            end
            ST_LVL: begin
                w.jc        = JC_LVL_FAIL;
                w.target    = ST_DONE;
                w.ctl.i_clr = 1'b1;
            end
            ST_RD: begin
                w.jc        = JC_NEXT;
                w.ctl.rd_en = 1'b1;
            end
            ST_WR: begin
                w.jc        = JC_WIN_MORE;
                w.target    = ST_RD;
                w.ctl.wr_en = 1'b1;
                w.ctl.i_inc = 1'b1;
            end
            ST_NXT: begin
                w.jc        = JC_ALWAYS;
                w.target    = ST_LVL;
                w.ctl.j_inc = 1'b1;
            end
            ST_DONE: begin
                w.jc            = JC_ALWAYS;
                w.target        = ST_IDLE;
                w.ctl.set_built = 1'b1;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Flat table address of level lvl, position idx.
    function automatic logic [ADDR_W-1:0] addr_of(input logic [J_W-1:0] lvl,
                                                  input logic [IDX_W-1:0] idx);
        return ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

>>> src/sparse_table_range_min_build.sv
// Load word: accepted, no result. Read word: one result, registered through the pending
// stage into the output register; the input stalls behind it while the read is pending.
// A load marked last starts the build, walked by the microcode sequencer with a read step
// and a write step per table entry, level by level while a level's window fits the loaded count.
// Synchronous active-low reset clears the count, the built flag and all handshake state;
// the table memory is not cleared and needs no clearing pass.
module sparse_table_range_min_build (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic signed [31:0]                i_element_value,
    input  logic                              i_last,
    input  logic [2:0]                        i_level,
    input  logic [5:0]                        i_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_entry_value,
    output logic                              o_entry_valid
);
    import stb_pkg::*;

    // Control and status between sequencer and datapath.
    t_ctl ctl;
    t_sts sts;
    logic busy;

    logic in_acc;
    logic load_en;
    logic query_en;
    logic start;

    logic signed [DATA_W-1:0] q_value;
    logic                     q_ok;

    // Read in flight: memory data lands in the cycle after acceptance.
    logic r_pend;
    logic r_out_valid;
    logic signed [DATA_W-1:0] r_entry_value;
    logic                     r_entry_valid;

    // Hold the input while building, while a read is in flight, or while a
    // result still waits and the far side holds it; a free output slot lets
    // the next word in while the last result is being taken.
    assign o_in_stall = busy || r_pend || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_en    = in_acc && !i_mode;
    assign query_en   = in_acc && i_mode;
    assign start      = load_en && i_last;

    stb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    stb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_load_en     (load_en),
        .i_load_value  (i_element_value),
        .i_query_en    (query_en),
        .i_query_level (i_level),
        .i_query_index (i_index),
        .o_q_value     (q_value),
        .o_q_ok        (q_ok)
    );

    // Advance the read into the output register; drop the result once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= query_en;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // An invalid window answers zero, whatever the memory holds there.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_entry_value <= q_ok ? q_value : '0;
            r_entry_valid <= q_ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_entry_value;
    assign o_entry_valid = r_entry_valid;

endmodule

>>> src/stb_seq.sv
module stb_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  stb_pkg::t_sts i_sts,
    output stb_pkg::t_ctl o_ctl,
    output logic          o_busy
);
    import stb_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ucw  ucw;
    logic  take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        ucw = ucode_rom(r_step);
        case (ucw.jc)
            JC_NEXT:      take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_NOT_START: take = !i_start;
            JC_LVL_FAIL:  take = !i_sts.lvl_fits;
            JC_WIN_MORE:  take = i_sts.win_more;
            default:      take = 1'b0;
        endcase
        n_step = take ? ucw.target : t_step'(r_step + 3'd1);
        o_ctl  = ucw.ctl;
        o_busy = (r_step != ST_IDLE);
    end

endmodule

>>> src/stb_dp.sv
module stb_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stb_pkg::t_ctl                        i_ctl,
    output stb_pkg::t_sts                        o_sts,
    input  logic                                 i_load_en,
    input  logic signed [stb_pkg::DATA_W-1:0]    i_load_value,
    input  logic                                 i_query_en,
    input  logic [stb_pkg::LVL_IN_W-1:0]         i_query_level,
    input  logic [stb_pkg::IDX_W-1:0]            i_query_index,
    output logic signed [stb_pkg::DATA_W-1:0]    o_q_value,
    output logic                                 o_q_ok
);
    import stb_pkg::*;

    logic signed [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;
    logic [CNT_W-1:0]         r_count;
    logic                     r_built;
    logic [J_W-1:0]           r_j;
    logic [IDX_W-1:0]         r_i;
    logic                     r_q_ok;

    logic [CNT_W-1:0]         base;
    logic                     store;
    logic [CMP_W-1:0]         pow;
    logic [CMP_W-1:0]         q_pow;
    logic                     q_ok;
    logic [J_W-1:0]           jm1;
    logic [IDX_W-1:0]         half;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rda_en;
    logic [ADDR_W-1:0]        rda_addr;
    logic [ADDR_W-1:0]        rdb_addr;

    always_comb begin
        // A load after a finished build opens a new data set.
        base  = r_built ? '0 : r_count;
        store = i_load_en && (base < CNT_W'(DEPTH));

        pow            = CMP_W'(1) << r_j;
        o_sts.lvl_fits = (r_j < J_W'(LEVELS)) && (pow <= CMP_W'(r_count));
        o_sts.win_more = (CMP_W'(r_i) + CMP_W'(1) + pow) <= CMP_W'(r_count);

        q_pow = CMP_W'(1) << i_query_level;
        q_ok  = r_built && (CMP_W'(i_query_level) < CMP_W'(LEVELS))
                && ((CMP_W'(i_query_index) + q_pow) <= CMP_W'(r_count));

        jm1  = r_j - J_W'(1);
        half = IDX_W'(1) << jm1;

        wr_en   = store || i_ctl.wr_en;
        wr_addr = i_ctl.wr_en ? addr_of(r_j, r_i) : ADDR_W'(base);
        wr_data = i_ctl.wr_en ? ((r_rd_a < r_rd_b) ? r_rd_a : r_rd_b) : i_load_value;

        rda_en   = i_ctl.rd_en || (i_query_en && q_ok);
        rda_addr = i_ctl.rd_en ? addr_of(jm1, r_i)
                               : addr_of(J_W'(i_query_level), i_query_index);
        rdb_addr = addr_of(jm1, r_i + half);
    end

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rda_en) begin
            r_rd_a <= r_mem[rda_addr];
        end
        if (i_ctl.rd_en) begin
            r_rd_b <= r_mem[rdb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_built <= 1'b0;
            r_q_ok  <= 1'b0;
        end else begin
            if (i_load_en) begin
                r_count <= store ? base + CNT_W'(1) : base;
                r_built <= 1'b0;
            end else if (i_ctl.set_built) begin
                r_built <= 1'b1;
            end
            if (i_query_en) begin
                r_q_ok <= q_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.j_init) begin
            r_j <= J_W'(1);
        end else if (i_ctl.j_inc) begin
            r_j <= r_j + J_W'(1);
        end
        if (i_ctl.i_clr) begin
            r_i <= '0;
        end else if (i_ctl.i_inc) begin
            r_i <= r_i + IDX_W'(1);
        end
    end

    assign o_q_value = r_rd_a;
    assign o_q_ok    = r_q_ok;

endmodule

>>> src/stb_chk.sv
`include "sparse_table_range_min_build_macros.svh"

module stb_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_mode,
    input logic signed [31:0] i_element_value,
    input logic               i_last,
    input logic [2:0]         i_level,
    input logic [5:0]         i_index,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_entry_value,
    input logic               o_entry_valid
);

    `STB_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_entry_value) && $stable(o_entry_valid), "result word changed while stalled")

    `STB_ASSERT_IMP(a_invalid_zero, o_out_valid && !o_entry_valid, o_entry_value == 32'sd0, "invalid result word carries a non-zero value")

    `STB_ASSERT_NXT(a_read_busy, i_in_valid && !o_in_stall && i_mode, o_in_stall, "input not held behind a read word")

    `STB_ASSERT_NXT(a_read_result, i_in_valid && !o_in_stall && i_mode, !o_out_valid ##1 o_out_valid, "read word result not shown two cycles on")

    `STB_ASSERT_NXT(a_build_busy, i_in_valid && !o_in_stall && !i_mode && i_last, o_in_stall, "input not held at build start")

endmodule

bind sparse_table_range_min_build stb_chk u_stb_chk (.*);
